/* src/svt_pkg.sv */
// Shared types, codes and helpers for the quote-aware SQL tokenizer.
// Used by the front, queue, back and top-level modules. No dependencies.
`timescale 1ns / 1ps

package svt_pkg;

  // Input item kinds (slave tuser).
  localparam logic IN_BYTE = 1'b0;
  localparam logic IN_END  = 1'b1;

  // Result kinds (master tuser).
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2
  } svt_kind_t;

  // Characters with a special role.
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;

  // Reset value of the escape enable register.
  localparam logic USE_ESCAPES_RESET = 1'b1;

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // One queued command: the results one input byte causes, in emission order
  // lead_end, has_byte, trail_end, done.
  typedef struct packed {
    logic [7:0] ch;
    logic       done;
    logic       trail_end;
    logic       has_byte;
    logic       lead_end;
  } svt_cmd_t;

  // True for the space and every terminator character.
  function automatic logic is_term(input logic [7:0] c);
    logic r;
    case (c) inside
      8'h20, 8'h28, 8'h2C, 8'h29, 8'h7E, 8'h21, 8'h5E, 8'h2A, 8'h2D,
      8'h2B, 8'h3D, 8'h3C, 8'h3E, 8'h2F, 8'h25, 8'h26, 8'h7C: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* src/svt_front.sv */
// Front end of the tokenizer: accepts input beats, tracks token and quote
// state, and turns each beat into a queued command. Depends on svt_pkg.
`timescale 1ns / 1ps

module svt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [7:0]        in_ch,
  output logic              push,
  output svt_pkg::svt_cmd_t push_cmd,
  input  logic              q_ready
);

  logic use_escapes;
  logic token_open, token_open_next;
  logic in_sq, in_sq_next;
  logic in_dq, in_dq_next;
  logic esc, esc_next;
  logic accept;
  logic quoted;

  assign cfg_ready = 1'b1;
  assign in_ready  = q_ready;
  assign accept    = in_valid && in_ready;
  assign quoted    = in_sq || in_dq;

  // Classify the byte and work out the state it leaves.
  always_comb begin
    token_open_next = token_open;
    in_sq_next      = in_sq;
    in_dq_next      = in_dq;
    esc_next        = esc;
    push_cmd        = '0;
    push_cmd.ch     = in_ch;
    if (in_kind == svt_pkg::IN_END) begin
      push_cmd.lead_end = token_open;
      push_cmd.done     = 1'b1;
      token_open_next   = 1'b0;
      in_sq_next        = 1'b0;
      in_dq_next        = 1'b0;
      esc_next          = 1'b0;
    end else if (token_open && esc) begin
      esc_next          = 1'b0;
      push_cmd.has_byte = 1'b1;
    end else if (!quoted && svt_pkg::is_term(in_ch)) begin
      push_cmd.lead_end = token_open;
      token_open_next   = 1'b0;
      if (in_ch != svt_pkg::CH_SPACE) begin
        push_cmd.has_byte  = 1'b1;
        push_cmd.trail_end = 1'b1;
      end
    end else begin
      token_open_next   = 1'b1;
      push_cmd.has_byte = 1'b1;
      if (use_escapes && quoted && in_ch == svt_pkg::CH_BACKSLASH) begin
        esc_next = 1'b1;
      end else if (!in_dq && in_ch == svt_pkg::CH_SQUOTE) begin
        in_sq_next = ~in_sq;
      end else if (!in_sq && in_ch == svt_pkg::CH_DQUOTE) begin
        in_dq_next = ~in_dq;
      end
    end
  end

  // A beat that causes no result never enters the queue.
  assign push = accept && (push_cmd.lead_end || push_cmd.has_byte || push_cmd.done);

  // State and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      use_escapes <= svt_pkg::USE_ESCAPES_RESET;
      token_open  <= 1'b0;
      in_sq       <= 1'b0;
      in_dq       <= 1'b0;
      esc         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        use_escapes <= cfg_data;
      end
      if (accept) begin
        token_open <= token_open_next;
        in_sq      <= in_sq_next;
        in_dq      <= in_dq_next;
        esc        <= esc_next;
      end
    end
  end

endmodule

/* src/svt_queue.sv */
// Small register FIFO of commands between the front and back ends.
// Depends on svt_pkg for the command type.
`timescale 1ns / 1ps

module svt_queue #(
  parameter int DEPTH = svt_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  svt_pkg::svt_cmd_t wr_cmd,
  output logic              rd_valid,
  input  logic              rd_pop,
  output svt_pkg::svt_cmd_t rd_cmd
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  svt_pkg::svt_cmd_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (count != FULL_CNT);
  assign rd_valid = (count != '0);
  assign rd_cmd   = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/svt_back.sv */
// Back end of the tokenizer: expands queued commands into result beats, one
// per unstalled cycle, via a registered output stage. Depends on svt_pkg.
`timescale 1ns / 1ps

module svt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  svt_pkg::svt_cmd_t q_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_ch,
  output logic              out_last
);

  logic [3:0] rem;
  logic [7:0] cur_ch;
  logic [3:0] low;
  logic [3:0] rem_left;
  logic       advance;
  logic       finishing;
  svt_pkg::svt_kind_t kind_sel;

  assign advance   = !out_valid || out_ready;
  assign low       = rem & (~rem + 4'd1);
  assign rem_left  = rem & ~low;
  assign finishing = (rem == '0) || (advance && rem_left == '0);
  assign q_pop     = q_valid && finishing;

  // Result kind of the next pending step.
  always_comb begin
    unique case (low)
      4'b0010: kind_sel = svt_pkg::KIND_BYTE;
      4'b1000: kind_sel = svt_pkg::KIND_DONE;
      default: kind_sel = svt_pkg::KIND_END;
    endcase
  end

  // Current command: pending-step mask and its byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (q_pop) begin
      rem <= {q_cmd.done, q_cmd.trail_end, q_cmd.has_byte, q_cmd.lead_end};
    end else if (advance) begin
      rem <= rem_left;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_ch <= q_cmd.ch;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= (rem != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind <= kind_sel;
      out_ch   <= (kind_sel == svt_pkg::KIND_BYTE) ? cur_ch : 8'h00;
      out_last <= (rem_left == '0);
    end
  end

endmodule

/* src/sql_verbatim_tokenizer.sv */
// Top level of the quote-aware SQL tokenizer: front end, command queue and
// back end. Depends on svt_pkg, svt_front, svt_queue and svt_back.
//
//   Channel   Dir  Handshake                Payload
//   cfg       in   cfg_valid / cfg_ready    cfg_data = use_escapes
//   s_axis    in   s_tvalid / s_tready      tdata = char_in, tuser = kind
//   m_axis    out  m_tvalid / m_tready      tdata = char_out, tuser = out_kind,
//                                           tlast = last
//
// The front end takes one input beat per cycle while the queue has room; its
// flag update is combinational. Each beat yields zero to three results, and
// the back end sends one result beat per cycle while m_tready is high. A
// result passes through the queue, the back end's pending-step register and
// the output register. Reset is synchronous and clears the control state;
// queue storage and output payload are not reset. The escape enable returns
// to 1. Output stalls fill the queue before s_tready drops.
`timescale 1ns / 1ps

module sql_verbatim_tokenizer #(
  parameter int QUEUE_DEPTH = svt_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,     // use_escapes
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,      // [7:0] char_in
  input  logic       s_tuser,      // [0] kind
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,      // [7:0] char_out
  output logic [1:0] m_tuser,      // [1:0] out_kind
  output logic       m_tlast       // last
);

  svt_pkg::svt_cmd_t push_cmd;
  svt_pkg::svt_cmd_t head_cmd;
  logic push;
  logic q_ready;
  logic q_valid;
  logic q_pop;

  // Front end: classification and token state.
  svt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (s_tuser),
    .in_ch     (s_tdata),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_ready   (q_ready)
  );

  // Command queue between the two ends.
  svt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push),
    .wr_ready (q_ready),
    .wr_cmd   (push_cmd),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_cmd   (head_cmd)
  );

  // Back end: result expansion and output register.
  svt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (head_cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_ch    (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

/* tb/sv/tb_sql_verbatim_tokenizer.sv */
// Self-checking testbench for the quote-aware SQL tokenizer: a directed table,
// then random queries, checked beat by beat against listed results or the
// predicted token stream. Depends on svt_pkg and sql_verbatim_tokenizer.
`timescale 1ns / 1ps

module tb_sql_verbatim_tokenizer;

  localparam int    PREDICT     = -1;    // row expectation comes from the predictor
  localparam int    RAND_ITEMS  = 450;
  localparam int    IDLE_LIMIT  = 3000;  // cycles without any accepted beat
  localparam int    SETTLE      = 4;     // pause before a register write
  localparam int    DRAIN       = 16;    // cycles allowed for stray results at the end
  localparam int    LONG_HOLD   = 400;   // one long output stall
  localparam string DELIMS      = " (,)~!^*-+=<>/%&|";

  // One result beat as the tokenizer emits it.
  typedef struct {
    svt_pkg::svt_kind_t kind;
    logic [7:0]         ch;
    logic               last;
  } tok_beat_t;

  // One stimulus row: an input beat or a write of the escape enable.
  typedef struct {
    bit                 is_cfg;
    logic               kind;
    logic [7:0]         ch;
    int                 n;
    svt_pkg::svt_kind_t k[3];
    logic [7:0]         c[3];
  } stim_row_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data  = 1'b0;
  logic       s_tvalid  = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata   = 8'h00;
  logic       s_tuser   = svt_pkg::IN_BYTE;
  logic       m_tvalid;
  logic       m_tready  = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  // Predictor state.
  bit esc_en       = 1'b1;
  bit tok_open     = 1'b0;
  bit in_sq        = 1'b0;
  bit in_dq        = 1'b0;
  bit shield       = 1'b0;

  tok_beat_t step_beats[$];
  tok_beat_t tok_expect[$];

  bit src_idle_on  = 1'b1;
  bit sink_idle_on = 1'b1;
  int sink_hold    = 0;
  int errors       = 0;
  int beats_in     = 0;
  int beats_out    = 0;
  int cfg_writes   = 0;
  int queries      = 0;
  int idle_cycles  = 0;

  sql_verbatim_tokenizer DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #1 clk = ~clk;

  // Space or any other byte that splits tokens outside quotes.
  function automatic bit is_delim(logic [7:0] c);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < DELIMS.len(); i++) begin
      if (DELIMS[i] == c) hit = 1'b1;
    end
    return hit;
  endfunction

  // Advance the predicted tokenizer by one input beat; results land in step_beats.
  function automatic void tokenize_byte(logic kind, logic [7:0] c);
    bit quoted;
    step_beats.delete();
    if (kind == svt_pkg::IN_END) begin
      if (tok_open) step_beats.push_back(tok_beat_t'{svt_pkg::KIND_END, 8'h00, 1'b0});
      step_beats.push_back(tok_beat_t'{svt_pkg::KIND_DONE, 8'h00, 1'b0});
      tok_open = 1'b0;
      in_sq    = 1'b0;
      in_dq    = 1'b0;
      shield   = 1'b0;
    end else if (tok_open && shield) begin
      // A shielded byte is taken as is.
      shield = 1'b0;
      step_beats.push_back(tok_beat_t'{svt_pkg::KIND_BYTE, c, 1'b0});
    end else begin
      quoted = in_sq || in_dq;
      if (!quoted && is_delim(c)) begin
        if (tok_open) begin
          step_beats.push_back(tok_beat_t'{svt_pkg::KIND_END, 8'h00, 1'b0});
          tok_open = 1'b0;
        end
        if (c != svt_pkg::CH_SPACE) begin
          step_beats.push_back(tok_beat_t'{svt_pkg::KIND_BYTE, c, 1'b0});
          step_beats.push_back(tok_beat_t'{svt_pkg::KIND_END, 8'h00, 1'b0});
        end
      end else begin
        tok_open = 1'b1;
        if (esc_en && quoted && c == svt_pkg::CH_BACKSLASH) shield = 1'b1;
        else if (!in_dq && c == svt_pkg::CH_SQUOTE) in_sq = !in_sq;
        else if (!in_sq && c == svt_pkg::CH_DQUOTE) in_dq = !in_dq;
        step_beats.push_back(tok_beat_t'{svt_pkg::KIND_BYTE, c, 1'b0});
      end
    end
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
  endfunction

  function automatic stim_row_t row(logic kind, logic [7:0] ch, int n = PREDICT,
                                    svt_pkg::svt_kind_t k0 = svt_pkg::KIND_BYTE,
                                    logic [7:0] c0 = 8'h00,
                                    svt_pkg::svt_kind_t k1 = svt_pkg::KIND_BYTE,
                                    logic [7:0] c1 = 8'h00,
                                    svt_pkg::svt_kind_t k2 = svt_pkg::KIND_BYTE,
                                    logic [7:0] c2 = 8'h00);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.kind   = kind;
    r.ch     = ch;
    r.n      = n;
    r.k[0]   = k0;
    r.k[1]   = k1;
    r.k[2]   = k2;
    r.c[0]   = c0;
    r.c[1]   = c1;
    r.c[2]   = c2;
    return r;
  endfunction

  function automatic stim_row_t wr(logic v);
    stim_row_t r;
    r        = row(svt_pkg::IN_BYTE, 8'h00);
    r.is_cfg = 1'b1;
    r.ch     = {7'd0, v};
    return r;
  endfunction

  // Byte mix for well-formed queries: words, spaces, terminators, quotes, escapes, noise.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 50) return svt_pkg::CH_SPACE;
    if (r < 65) return 8'(DELIMS[$urandom_range(0, DELIMS.len() - 1)]);
    if (r < 75) return svt_pkg::CH_SQUOTE;
    if (r < 83) return svt_pkg::CH_DQUOTE;
    if (r < 90) return svt_pkg::CH_BACKSLASH;
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one input beat, then record what it should produce.
  task automatic send_beat(input stim_row_t r);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= r.ch;
    s_tuser  <= r.kind;
    do @(posedge clk); while (s_tready !== 1'b1);
    tokenize_byte(r.kind, r.ch);
    if (r.n >= 0) begin
      for (int i = 0; i < r.n; i++) begin
        tok_expect.push_back(tok_beat_t'{r.k[i], r.c[i], (i == r.n - 1)});
      end
    end else begin
      foreach (step_beats[i]) tok_expect.push_back(step_beats[i]);
    end
    beats_in++;
  endtask

  // Write the escape enable once the block has gone quiet.
  task automatic write_escapes(input logic v);
    s_tvalid <= 1'b0;
    while (tok_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    esc_en = v;
    cfg_writes++;
  endtask

  // Output side: random stalls, one long hold on request, and the beat check.
  initial begin
    int        gap;
    tok_beat_t e;
    forever begin
      if (sink_hold > 0) gap = sink_hold;
      else gap = sink_idle_on ? $urandom_range(0, 14) : 0;
      sink_hold = 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (rst || m_tvalid !== 1'b1);
      beats_out++;
      if (tok_expect.size() == 0) begin
        $error("unexpected result beat: out_kind %0d char_out %02h last %0b",
               m_tuser, m_tdata, m_tlast);
        errors++;
      end else begin
        e = tok_expect.pop_front();
        if (m_tuser !== e.kind) begin
          $error("out_kind: expected %0d, got %0d", e.kind, m_tuser);
          errors++;
        end
        if (m_tdata !== e.ch) begin
          $error("char_out: expected %02h, got %02h", e.ch, m_tdata);
          errors++;
        end
        if (m_tlast !== e.last) begin
          $error("last: expected %0b, got %0b", e.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which no channel moves a beat.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without a beat", IDLE_LIMIT);
        $display("sql_verbatim_tokenizer: mismatch");
        $finish;
      end
    end
  end

  // Stimulus: directed table, then random queries.
  initial begin
    stim_row_t dir_rows[$];
    int        rand_count;
    int        qlen;
    int        cfg_at;
    bit        noisy;
    bit        pressure_done;

    // Empty start, single-character tokens, extreme bytes.
    dir_rows.push_back(row(svt_pkg::IN_BYTE, svt_pkg::CH_SPACE, 0));
    dir_rows.push_back(row(svt_pkg::IN_END, 8'h00, 1, svt_pkg::KIND_DONE, 8'h00));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, "(", 2, svt_pkg::KIND_BYTE, "(",
                           svt_pkg::KIND_END, 8'h00));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, 8'h00, 1, svt_pkg::KIND_BYTE, 8'h00));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, 8'hFF, 1, svt_pkg::KIND_BYTE, 8'hFF));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, "+", 3, svt_pkg::KIND_END, 8'h00,
                           svt_pkg::KIND_BYTE, "+", svt_pkg::KIND_END, 8'h00));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, "a"));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, svt_pkg::CH_SPACE, 1,
                           svt_pkg::KIND_END, 8'h00));
    // Single quotes: terminators inside, escaped quote, doubled quote.
    dir_rows.push_back(row(svt_pkg::IN_BYTE, svt_pkg::CH_SQUOTE));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, svt_pkg::CH_SPACE));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, "|"));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, svt_pkg::CH_BACKSLASH));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, svt_pkg::CH_SQUOTE));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, svt_pkg::CH_SQUOTE));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, svt_pkg::CH_SQUOTE));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, svt_pkg::CH_DQUOTE));
    // End of query while still inside quotes.
    dir_rows.push_back(row(svt_pkg::IN_END, 8'hFF, 2, svt_pkg::KIND_END, 8'h00,
                           svt_pkg::KIND_DONE, 8'h00));
    // Escapes switched off while a shield is pending.
    dir_rows.push_back(row(svt_pkg::IN_BYTE, svt_pkg::CH_DQUOTE));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, ","));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, svt_pkg::CH_BACKSLASH));
    dir_rows.push_back(wr(1'b0));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, svt_pkg::CH_DQUOTE));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, svt_pkg::CH_BACKSLASH));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, svt_pkg::CH_DQUOTE));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, svt_pkg::CH_BACKSLASH));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, "="));
    // Backslash as the final byte of a query.
    dir_rows.push_back(wr(1'b1));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, svt_pkg::CH_DQUOTE));
    dir_rows.push_back(row(svt_pkg::IN_BYTE, svt_pkg::CH_BACKSLASH));
    dir_rows.push_back(row(svt_pkg::IN_END, 8'h00));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_escapes(dir_rows[i].ch[0]);
      else send_beat(dir_rows[i]);
    end

    // Random queries: mostly well formed, some raw noise, a few left unterminated.
    rand_count    = 0;
    pressure_done = 1'b0;
    while (rand_count < RAND_ITEMS) begin
      qlen         = $urandom_range(1, 20);
      noisy        = ($urandom_range(0, 9) == 0);
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      cfg_at       = ($urandom_range(0, 5) == 0) ? $urandom_range(0, qlen - 1) : -1;
      for (int i = 0; i < qlen; i++) begin
        if (i == cfg_at) write_escapes(!esc_en);
        if (!pressure_done && rand_count >= 200) begin
          // Hold the output off long enough for the input to back up.
          sink_hold     = LONG_HOLD;
          src_idle_on   = 1'b0;
          pressure_done = 1'b1;
        end
        send_beat(row(svt_pkg::IN_BYTE,
                      noisy ? 8'($urandom_range(0, 255)) : pick_char()));
        rand_count++;
      end
      if ($urandom_range(0, 19) != 0) begin
        send_beat(row(svt_pkg::IN_END, 8'($urandom_range(0, 255))));
        rand_count++;
        queries++;
      end
    end

    s_tvalid <= 1'b0;
    while (tok_expect.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d input beats over %0d closed queries with %0d escape-enable writes.",
             beats_in, queries, cfg_writes);
    $display("Checked %0d result beats, including one %0d-cycle output hold.",
             beats_out, LONG_HOLD);
    if (errors == 0) begin
      $display("sql_verbatim_tokenizer: match");
    end else begin
      $display("sql_verbatim_tokenizer: mismatch");
    end
    $finish;
  end

endmodule
